// File: rtl/core/fpar_pkg.sv
`timescale 1ns / 1ps
package fpar_pkg;
  localparam int MaxBits = 64;
  localparam int WideBits = 128;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_CONV = 4'd3;
  localparam logic [3:0] OP_SHL = 4'd4;
  localparam logic [3:0] OP_SHR = 4'd5;
  localparam logic [3:0] OP_AND = 4'd6;
  localparam logic [3:0] OP_OR = 4'd7;
  localparam logic [3:0] OP_NOT = 4'd8;
  localparam logic [3:0] OP_NEG = 4'd9;

  localparam logic [1:0] OVF_SAT = 2'd0;
  localparam logic [1:0] OVF_ZERO = 2'd1;
  localparam logic [1:0] OVF_WRAP = 2'd2;
  localparam logic [1:0] OVF_ERR = 2'd3;

  localparam logic [2:0] REG_A_FRAC = 3'd0;
  localparam logic [2:0] REG_B_FRAC = 3'd1;
  localparam logic [2:0] REG_LEN = 3'd2;
  localparam logic [2:0] REG_R_FRAC = 3'd3;
  localparam logic [2:0] REG_UNS = 3'd4;
  localparam logic [2:0] REG_OVF = 3'd5;
  localparam logic [2:0] REG_RND = 3'd6;

  typedef struct packed {
    logic [5:0] a_frac;
    logic [5:0] b_frac;
    logic [6:0] len;
    logic [5:0] r_frac;
    logic       uns;
    logic [1:0] ovf_mode;
    logic       rnd;
  } cfg_t;
endpackage

// File: rtl/core/fpar_cell.sv
`timescale 1ns / 1ps
// One pipeline cell: a register slice that advances when the next cell is free.
module fpar_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  logic         full;
  logic [W-1:0] data;

  assign in_ready  = !full || out_ready;
  assign out_valid = full;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end
endmodule

// File: rtl/core/fixed_point_alu_requantize.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output is not stalled.
// Cells: operand alignment and partial products, exact value, requantise,
// overflow handling. Each cell holds its request while the next one stalls.
// Reset (rst, synchronous): pipeline empties, registers take their defaults
// (result_length 24, all else 0).
module fixed_point_alu_requantize #(
  parameter int MAX_BITS = fpar_pkg::MaxBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  req_type,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  input  logic [5:0]  shift_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] result_value,
  output logic        overflowed,
  output logic        error_flag,
  output logic        a_less_than_b,
  output logic        a_equal_b,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam logic [6:0] MaxLen = 7'(MAX_BITS);

  fpar_pkg::cfg_t cfg;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{a_frac: 6'd0, b_frac: 6'd0, len: 7'd24, r_frac: 6'd0,
               uns: 1'b0, ovf_mode: fpar_pkg::OVF_SAT, rnd: 1'b0};
    end else if (cfg_valid) begin
      case (cfg_index)
        fpar_pkg::REG_A_FRAC: cfg.a_frac <= cfg_data[5:0];
        fpar_pkg::REG_B_FRAC: cfg.b_frac <= cfg_data[5:0];
        fpar_pkg::REG_LEN: cfg.len <= cfg_data[6:0];
        fpar_pkg::REG_R_FRAC: cfg.r_frac <= cfg_data[5:0];
        fpar_pkg::REG_UNS: cfg.uns <= cfg_data[0];
        fpar_pkg::REG_OVF: cfg.ovf_mode <= cfg_data[1:0];
        fpar_pkg::REG_RND: cfg.rnd <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: align, compare, partial products
  typedef struct packed {
    logic [3:0]   op;
    logic [127:0] a;
    logic [127:0] b;
    logic [63:0]  ra;
    logic [5:0]   s;
    logic [6:0]   fc;
    logic [63:0]  p00, p01, p10, p11;
    logic [63:0]  corr;
    logic         lt, eq;
  } s1_t;

  s1_t s1_d, s1_q;
  logic v1, r1;

  always_comb begin
    logic [5:0]   fc;
    logic [127:0] ea, eb;
    fc = (cfg.a_frac > cfg.b_frac) ? cfg.a_frac : cfg.b_frac;
    ea = {{64{operand_a[63]}}, operand_a};
    eb = {{64{operand_b[63]}}, operand_b};
    s1_d.op = req_type;
    s1_d.a = ea << (fc - cfg.a_frac);
    s1_d.b = eb << (fc - cfg.b_frac);
    s1_d.ra = operand_a;
    s1_d.s = shift_amount;
    s1_d.fc = {1'b0, fc};
    s1_d.p00 = 64'(operand_a[31:0]) * 64'(operand_b[31:0]);
    s1_d.p01 = 64'(operand_a[31:0]) * 64'(operand_b[63:32]);
    s1_d.p10 = 64'(operand_a[63:32]) * 64'(operand_b[31:0]);
    s1_d.p11 = 64'(operand_a[63:32]) * 64'(operand_b[63:32]);
    s1_d.corr = (operand_a[63] ? operand_b : 64'd0) + (operand_b[63] ? operand_a : 64'd0);
    s1_d.lt = $signed(s1_d.a) < $signed(s1_d.b);
    s1_d.eq = s1_d.a == s1_d.b;
  end

  fpar_cell #(.W($bits(s1_t))) u_c1 (
    .clk, .rst, .in_valid(in_valid), .in_ready(in_ready), .in_data(s1_d),
    .out_valid(v1), .out_ready(r1), .out_data(s1_q));

  // ---------------- stage 2: exact value and its fraction count
  typedef struct packed {
    logic [127:0] v;
    logic [6:0]   fv;
    logic         lt, eq;
  } s2_t;

  s2_t s2_d, s2_q;
  logic v2, r2;

  always_comb begin
    logic [127:0] ea, pm;
    ea = {{64{s1_q.ra[63]}}, s1_q.ra};
    pm = {s1_q.p11, 64'd0} + {32'd0, s1_q.p01, 32'd0} + {32'd0, s1_q.p10, 32'd0}
         + {64'd0, s1_q.p00} - {s1_q.corr, 64'd0};
    s2_d.lt = s1_q.lt;
    s2_d.eq = s1_q.eq;
    s2_d.v = '0;
    s2_d.fv = 7'd0;
    case (s1_q.op)
      fpar_pkg::OP_ADD: begin s2_d.v = s1_q.a + s1_q.b; s2_d.fv = s1_q.fc; end
      fpar_pkg::OP_SUB: begin s2_d.v = s1_q.a - s1_q.b; s2_d.fv = s1_q.fc; end
      fpar_pkg::OP_MUL: begin s2_d.v = pm; s2_d.fv = 7'(cfg.a_frac) + 7'(cfg.b_frac); end
      fpar_pkg::OP_CONV: begin s2_d.v = ea; s2_d.fv = 7'(cfg.a_frac); end
      fpar_pkg::OP_SHL: begin s2_d.v = ea << s1_q.s; s2_d.fv = 7'(cfg.a_frac); end
      fpar_pkg::OP_SHR: begin s2_d.v = ea; s2_d.fv = 7'(cfg.a_frac) + 7'(s1_q.s); end
      fpar_pkg::OP_AND: begin s2_d.v = s1_q.a & s1_q.b; s2_d.fv = s1_q.fc; end
      fpar_pkg::OP_OR: begin s2_d.v = s1_q.a | s1_q.b; s2_d.fv = s1_q.fc; end
      fpar_pkg::OP_NOT: begin s2_d.v = ~ea; s2_d.fv = 7'(cfg.a_frac); end
      fpar_pkg::OP_NEG: begin s2_d.v = -ea; s2_d.fv = 7'(cfg.a_frac); end
      default: ;
    endcase
  end

  fpar_cell #(.W($bits(s2_t))) u_c2 (
    .clk, .rst, .in_valid(v1), .in_ready(r1), .in_data(s2_d),
    .out_valid(v2), .out_ready(r2), .out_data(s2_q));

  // ---------------- stage 3: align to result fraction, round
  typedef struct packed {
    logic [127:0] q;
    logic         big;
    logic         vneg;
    logic         lt, eq;
  } s3_t;

  s3_t s3_d, s3_q;
  logic v3, r3;

  always_comb begin
    logic [6:0]   k;
    logic [127:0] q, back;
    logic         rb;
    q = '0;
    back = '0;
    rb = 1'b0;
    k = 7'd0;
    s3_d.big = 1'b0;
    if (7'(cfg.r_frac) >= s2_q.fv) begin
      k = 7'(cfg.r_frac) - s2_q.fv;
      q = s2_q.v << k;
      back = $signed(q) >>> k;
      s3_d.big = back != s2_q.v;
    end else begin
      k = s2_q.fv - 7'(cfg.r_frac);
      q = $signed(s2_q.v) >>> k;
      rb = s2_q.v[k - 7'd1];
      if (cfg.rnd && rb) q = q + 128'd1;
    end
    s3_d.q = q;
    s3_d.vneg = s3_d.big ? s2_q.v[127] : q[127];
    s3_d.lt = s2_q.lt;
    s3_d.eq = s2_q.eq;
  end

  fpar_cell #(.W($bits(s3_t))) u_c3 (
    .clk, .rst, .in_valid(v2), .in_ready(r2), .in_data(s3_d),
    .out_valid(v3), .out_ready(r3), .out_data(s3_q));

  // ---------------- stage 4: range check and overflow handling
  typedef struct packed {
    logic [63:0] res;
    logic        ovf, err, lt, eq;
  } s4_t;

  s4_t s4_d, s4_q;

  always_comb begin
    logic [6:0]   len;
    logic [127:0] t;
    logic         fits;
    logic [63:0]  mask, res;
    len = (cfg.len == 7'd0) ? 7'd1 : ((cfg.len > MaxLen) ? MaxLen : cfg.len);
    if (s3_q.big) begin
      t = '0;
      fits = 1'b0;
    end else if (cfg.uns) begin
      t = $signed(s3_q.q) >>> len;
      fits = !s3_q.q[127] && (t == '0);
    end else begin
      t = $signed(s3_q.q) >>> (len - 7'd1);
      fits = (t == '0) || (&t);
    end
    mask = (len >= 7'd64) ? '1 : ((64'd1 << len) - 64'd1);
    res = s3_q.q[63:0] & mask;
    if (!cfg.uns && len < 7'd64 && res[6'(len - 7'd1)]) res = res | ~mask;
    s4_d.err = 1'b0;
    if (!fits) begin
      case (cfg.ovf_mode)
        fpar_pkg::OVF_SAT:
          if (cfg.uns) res = s3_q.vneg ? 64'd0 : mask;
          else res = s3_q.vneg ? ~(mask >> 1) : (mask >> 1);
        fpar_pkg::OVF_ZERO: res = '0;
        fpar_pkg::OVF_WRAP: ;
        default: begin res = '0; s4_d.err = 1'b1; end
      endcase
    end
    s4_d.res = res;
    s4_d.ovf = !fits;
    s4_d.lt = s3_q.lt;
    s4_d.eq = s3_q.eq;
  end

  fpar_cell #(.W($bits(s4_t))) u_c4 (
    .clk, .rst, .in_valid(v3), .in_ready(r3), .in_data(s4_d),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(s4_q));

  assign result_value  = s4_q.res;
  assign overflowed    = s4_q.ovf;
  assign error_flag    = s4_q.err;
  assign a_less_than_b = s4_q.lt;
  assign a_equal_b     = s4_q.eq;

  a_err_implies_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> overflowed && result_value == 64'd0)
    else $error("error flag without overflow");
  a_lt_eq_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(a_less_than_b && a_equal_b))
    else $error("less and equal both set");
  a_no_accept_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && out_valid && !out_ready |-> !in_ready)
    else $error("request taken into a full pipeline");
endmodule
